// File: rtl/csvft_pkg.sv
// csvft_pkg: shared types and constants of the CSV field tokenizer.
// Used by the decoder, the result queue, the tokenizer core and the top level.
package csvft_pkg;

  // Result kinds
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_END  = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;

  // Special bytes
  localparam logic [7:0] QUOTE_BYTE   = 8'h22;
  localparam logic [7:0] NEWLINE_BYTE = 8'h0A;
  localparam logic [7:0] DELIM_RESET  = 8'h2C;

  // Result queue geometry
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QFILL_W     = 3;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] out_byte;
    logic       last;
  } result_t;

  typedef struct packed {
    logic in_quotes;
    logic field_started;
    logic quote_pending;
  } field_state_t;

  // Decoder output: new parse state and up to two results
  typedef struct packed {
    field_state_t state_next;
    logic [1:0]   count;
    result_t      res0;
    result_t      res1;
  } decode_t;

endpackage

// File: rtl/csvft_ifs.sv
// csvft_ifs: valid/ready channels for input words and result words.
// Does not import csvft_pkg; its byte and kind widths mirror those of the package.
interface csvft_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_input;

  modport source (output valid, output in_byte, output end_of_input, input ready);
  modport sink   (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvft_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;
  logic       last;

  modport source (output valid, output kind, output out_byte, output last, input ready);
  modport sink   (input valid, input kind, input out_byte, input last, output ready);
endinterface

// File: rtl/csv_field_tokenizer.sv
// csv_field_tokenizer: top level. A word is accepted into an input register,
// parsed by one level of logic and its results pushed into a four-word queue.
// Results are registered in the queue before they reach the output port.
// Throughput: one input word per cycle; input stalls while the queue lacks room for two
// words, as after newlines ending a started field, which add two results to the one-word-per-cycle output.
// Reset (rst, synchronous): parse state cleared, delimiter set to comma, queue emptied.
module csv_field_tokenizer (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_wr_en,
  input  logic [7:0]      cfg_wr_data,
  csvft_in_if.sink        in_ch,
  csvft_out_if.source     out_ch
);

  logic                space;
  logic [1:0]          push_count;
  csvft_pkg::result_t  push0;
  csvft_pkg::result_t  push1;
  csvft_pkg::result_t  head;
  logic                avail;

  csvft_tokenizer_core u_core (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_byte      (in_ch.in_byte),
    .end_of_input (in_ch.end_of_input),
    .space        (space),
    .push_count   (push_count),
    .push0        (push0),
    .push1        (push1)
  );

  csvft_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (push0),
    .push1      (push1),
    .space      (space),
    .pop        (out_ch.ready),
    .avail      (avail),
    .head       (head)
  );

  // Drive result port from queue head
  assign out_ch.valid    = avail;
  assign out_ch.kind     = head.kind;
  assign out_ch.out_byte = head.out_byte;
  assign out_ch.last     = head.last;

`ifndef SYNTHESIS
  a_kind_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.kind == csvft_pkg::KIND_BYTE || out_ch.out_byte == 8'h00))
    else $error("non-byte result carries a byte");
`endif

endmodule

// File: rtl/csvft_decode.sv
// csvft_decode: combinational parse of one byte against the field state.
// Depends on csvft_pkg for the state, result and decode types.
module csvft_decode (
  input  logic [7:0]             in_byte,
  input  logic                   end_of_input,
  input  logic [7:0]             delimiter,
  input  csvft_pkg::field_state_t state,
  output csvft_pkg::decode_t     dec
);

  logic is_delim;
  logic is_nl;
  logic is_quote;
  logic is_blank;

  assign is_delim = (in_byte == delimiter);
  assign is_nl    = (in_byte == csvft_pkg::NEWLINE_BYTE);
  assign is_quote = (in_byte == csvft_pkg::QUOTE_BYTE);
  assign is_blank = (in_byte == 8'h20) || (in_byte == 8'h09) || (in_byte == 8'h0B) ||
                    (in_byte == 8'h0C) || (in_byte == 8'h0D);

  // Decide results and next state
  always_comb begin
    dec.state_next    = state;
    dec.count         = 2'd0;
    dec.res0.kind     = csvft_pkg::KIND_BYTE;
    dec.res0.out_byte = 8'h00;
    dec.res0.last     = 1'b0;
    dec.res1.kind     = csvft_pkg::KIND_NONE;
    dec.res1.out_byte = 8'h00;
    dec.res1.last     = 1'b1;

    if (end_of_input) begin
      dec.res0.kind  = state.field_started ? csvft_pkg::KIND_END : csvft_pkg::KIND_NONE;
      dec.count      = 2'd1;
      dec.state_next = '0;
    end else if (state.quote_pending) begin
      dec.count = 2'd1;
      if (is_delim || is_nl) begin
        dec.res0.kind  = csvft_pkg::KIND_END;
        dec.state_next = '0;
      end else begin
        dec.res0.out_byte             = in_byte;
        dec.state_next.quote_pending  = 1'b0;
      end
    end else if (!state.in_quotes && is_delim) begin
      dec.res0.kind  = state.field_started ? csvft_pkg::KIND_END : csvft_pkg::KIND_NONE;
      dec.count      = 2'd1;
      dec.state_next = '0;
    end else if (is_nl) begin
      // Newline: field end (if started) then no-field
      if (state.field_started) begin
        dec.res0.kind = csvft_pkg::KIND_END;
        dec.count     = 2'd2;
      end else begin
        dec.res0.kind = csvft_pkg::KIND_NONE;
        dec.count     = 2'd1;
      end
      dec.state_next = '0;
    end else if (!state.field_started && !state.in_quotes && is_blank) begin
      // drop leading white space
    end else if (!state.field_started && is_quote) begin
      dec.state_next.in_quotes = 1'b1;
    end else if (is_quote && state.in_quotes) begin
      dec.state_next.quote_pending = 1'b1;
    end else begin
      dec.res0.out_byte            = in_byte;
      dec.count                    = 2'd1;
      dec.state_next.field_started = 1'b1;
    end

    dec.res0.last = (dec.count == 2'd1);
  end

endmodule

// File: rtl/csvft_queue.sv
// csvft_queue: small result queue taking up to two words per cycle.
// Depends on csvft_pkg for result_t and the queue geometry.
module csvft_queue (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [1:0]                   push_count,
  input  csvft_pkg::result_t           push0,
  input  csvft_pkg::result_t           push1,
  output logic                         space,
  input  logic                         pop,
  output logic                         avail,
  output csvft_pkg::result_t           head
);

  csvft_pkg::result_t                 mem [csvft_pkg::QUEUE_DEPTH];
  logic [csvft_pkg::QPTR_W-1:0]       wr_ptr;
  logic [csvft_pkg::QPTR_W-1:0]       rd_ptr;
  logic [csvft_pkg::QFILL_W-1:0]      fill;
  logic [csvft_pkg::QPTR_W-1:0]       wr_ptr1;
  logic                               pop_ok;

  assign wr_ptr1 = wr_ptr + 1'b1;
  assign avail   = (fill != '0);
  assign pop_ok  = pop && avail;
  assign head    = mem[rd_ptr];
  // Room for two words once this cycle's pop is counted
  assign space   = (fill <= csvft_pkg::QFILL_W'(csvft_pkg::QUEUE_DEPTH - 2)) ||
                   ((fill == csvft_pkg::QFILL_W'(csvft_pkg::QUEUE_DEPTH - 1)) && pop_ok);

  // Store pushed words
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      mem[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      mem[wr_ptr1] <= push1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      wr_ptr <= wr_ptr + csvft_pkg::QPTR_W'(push_count);
      if (pop_ok) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fill <= fill + csvft_pkg::QFILL_W'(push_count) - csvft_pkg::QFILL_W'(pop_ok);
    end
  end

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= csvft_pkg::QFILL_W'(csvft_pkg::QUEUE_DEPTH))
    else $error("result queue overfilled");

  a_push_needs_space: assert property (@(posedge clk) disable iff (rst)
    (push_count != 2'd0) |-> space)
    else $error("push into queue without room for two words");
`endif

endmodule

// File: rtl/csvft_tokenizer_core.sv
// csvft_tokenizer_core: input register, parse state and delimiter register.
// Depends on csvft_pkg and csvft_decode; feeds the result queue.
module csvft_tokenizer_core (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_byte,
  input  logic                 end_of_input,
  input  logic                 space,
  output logic [1:0]           push_count,
  output csvft_pkg::result_t   push0,
  output csvft_pkg::result_t   push1
);

  logic                     stage_valid;
  logic [7:0]               stage_byte;
  logic                     stage_eoi;
  logic [7:0]               delimiter;
  csvft_pkg::field_state_t  state;
  csvft_pkg::decode_t       dec;
  logic                     fire;

  csvft_decode u_decode (
    .in_byte      (stage_byte),
    .end_of_input (stage_eoi),
    .delimiter    (delimiter),
    .state        (state),
    .dec          (dec)
  );

  assign fire       = stage_valid && space;
  assign in_ready   = !stage_valid || fire;
  assign push_count = fire ? dec.count : 2'd0;
  assign push0      = dec.res0;
  assign push1      = dec.res1;

  // Hold the accepted word
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_byte <= in_byte;
      stage_eoi  <= end_of_input;
    end
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
      state       <= '0;
      delimiter   <= csvft_pkg::DELIM_RESET;
    end else begin
      if (in_ready) begin
        stage_valid <= in_valid;
      end
      if (fire) begin
        state <= dec.state_next;
      end
      if (cfg_wr_en) begin
        delimiter <= cfg_wr_data;
      end
    end
  end

`ifndef SYNTHESIS
  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !fire) |=> (stage_valid && $stable(stage_byte) && $stable(stage_eoi)))
    else $error("stalled input word changed");

  a_two_results_last: assert property (@(posedge clk) disable iff (rst)
    (fire && dec.count == 2'd2) |-> (!dec.res0.last && dec.res0.kind == csvft_pkg::KIND_END))
    else $error("two-result word misformed");
`endif

endmodule

// File: sim/testbench.sv
// testbench: self-checking bench for csv_field_tokenizer.
// Depends on rtl/csvft_pkg.sv and rtl/csvft_ifs.sv; drives random CSV text and
// checks every result word against an in-bench tokenizer model.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_HALF      = 5;
  localparam int RESET_CYCLES  = 12;
  localparam int SETTLE_CYCLES = 4;
  localparam int HOLD_CYCLES   = 64;
  localparam int QUIET_LIMIT   = 2000;
  localparam int PHASE_ITEMS   = 210;
  localparam int NUM_PHASES    = 9;
  localparam int MAX_REPORTS   = 20;
  localparam int PREDICT       = -1;

  localparam logic [7:0] SPACE_BYTE = 8'h20;
  localparam logic [7:0] TAB_BYTE   = 8'h09;
  localparam logic [7:0] VT_BYTE    = 8'h0B;
  localparam logic [7:0] FF_BYTE    = 8'h0C;
  localparam logic [7:0] CR_BYTE    = 8'h0D;

  typedef struct {
    logic [7:0]         b;
    logic               eoi;
    int                 n;
    csvft_pkg::result_t r0;
    csvft_pkg::result_t r1;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;

  csvft_in_if  in_ch ();
  csvft_out_if out_ch ();

  csv_field_tokenizer dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_ch       (in_ch),
    .out_ch      (out_ch)
  );

  // Tokenizer model state and the delimiter it believes is loaded
  logic [7:0] delim = csvft_pkg::DELIM_RESET;
  logic quoted = 1'b0;
  logic has_value = 1'b0;
  logic quote_held = 1'b0;

  csvft_pkg::result_t token_q[$];
  stim_row_t dir_rows[$];
  logic [7:0] blank_set [5];
  logic [7:0] phase_delims [NUM_PHASES];

  int  mismatches = 0;
  int  items_sent = 0;
  int  quiet_cycles = 0;
  bit  src_idle = 1'b1;
  bit  snk_idle = 1'b1;
  bit  long_hold_req = 1'b0;

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // Close the current field in the model
  function automatic void field_done();
    quoted = 1'b0;
    has_value = 1'b0;
    quote_held = 1'b0;
  endfunction

  // Advance the model by one input word; return the number of result words
  function automatic int tokenize(input logic [7:0] b, input logic eoi,
                                  output csvft_pkg::result_t r0,
                                  output csvft_pkg::result_t r1);
    int n;
    n = 0;
    r0 = '0;
    r1 = '0;
    if (eoi) begin
      r0.kind = has_value ? csvft_pkg::KIND_END : csvft_pkg::KIND_NONE;
      n = 1;
      field_done();
    end else if (quote_held) begin
      // a held quote: delimiter or newline closes, anything else is data
      if (b == delim || b == csvft_pkg::NEWLINE_BYTE) begin
        r0.kind = csvft_pkg::KIND_END;
        n = 1;
        field_done();
      end else begin
        r0.kind = csvft_pkg::KIND_BYTE;
        r0.out_byte = b;
        n = 1;
        quote_held = 1'b0;
      end
    end else if (!quoted && b == delim) begin
      r0.kind = has_value ? csvft_pkg::KIND_END : csvft_pkg::KIND_NONE;
      n = 1;
      field_done();
    end else if (b == csvft_pkg::NEWLINE_BYTE) begin
      if (has_value) begin
        r0.kind = csvft_pkg::KIND_END;
        r1.kind = csvft_pkg::KIND_NONE;
        n = 2;
      end else begin
        r0.kind = csvft_pkg::KIND_NONE;
        n = 1;
      end
      field_done();
    end else if (!has_value && !quoted && (b == SPACE_BYTE || b == TAB_BYTE ||
                 b == VT_BYTE || b == FF_BYTE || b == CR_BYTE)) begin
      // skip leading white space
    end else if (!has_value && b == csvft_pkg::QUOTE_BYTE) begin
      quoted = 1'b1;
    end else if (b == csvft_pkg::QUOTE_BYTE && quoted) begin
      quote_held = 1'b1;
    end else begin
      r0.kind = csvft_pkg::KIND_BYTE;
      r0.out_byte = b;
      n = 1;
      has_value = 1'b1;
    end
    if (n == 1) r0.last = 1'b1;
    if (n == 2) r1.last = 1'b1;
    return n;
  endfunction

  // Append a directed word; n of PREDICT leaves the result to the model
  function automatic void add_row(input logic [7:0] b, input logic eoi, input int n,
                                  input logic [1:0] k0 = csvft_pkg::KIND_BYTE,
                                  input logic [7:0] ob0 = 8'h00,
                                  input logic [1:0] k1 = csvft_pkg::KIND_BYTE);
    stim_row_t row;
    row.b = b;
    row.eoi = eoi;
    row.n = n;
    row.r0 = '0;
    row.r1 = '0;
    row.r0.kind = k0;
    row.r0.out_byte = ob0;
    row.r1.kind = k1;
    if (n == 1) row.r0.last = 1'b1;
    if (n == 2) row.r1.last = 1'b1;
    dir_rows.push_back(row);
  endfunction

  task automatic report_mismatch(input string field, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch: got %0d, want %0d", $time, field, got, want);
  endtask

  // Offer one word, after a random gap when src_idle is set, and hold it until accepted
  task automatic offer_word(input logic [7:0] b, input logic eoi);
    int gap;
    gap = src_idle ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_word(input logic [7:0] b, input logic eoi);
    csvft_pkg::result_t r0, r1;
    int n;
    offer_word(b, eoi);
    n = tokenize(b, eoi, r0, r1);
    if (n > 0) token_q.push_back(r0);
    if (n > 1) token_q.push_back(r1);
  endtask

  // Send one well-formed field: optional blanks, optional quoting, terminator
  task automatic send_field();
    int blanks, len, term;
    logic is_quoted;
    logic [7:0] c;
    is_quoted = 1'($urandom_range(0, 1));
    blanks = $urandom_range(0, 2) == 0 ? $urandom_range(1, 2) : 0;
    repeat (blanks) send_word(blank_set[$urandom_range(0, 4)], 1'b0);
    if (is_quoted) send_word(csvft_pkg::QUOTE_BYTE, 1'b0);
    len = $urandom_range(0, 6);
    repeat (len) begin
      if (is_quoted && $urandom_range(0, 5) == 0) begin
        send_word(csvft_pkg::QUOTE_BYTE, 1'b0);
        send_word(csvft_pkg::QUOTE_BYTE, 1'b0);
      end else begin
        do c = 8'($urandom_range(0, 255));
        while (c == csvft_pkg::NEWLINE_BYTE || (!is_quoted && c == delim) ||
               (is_quoted && c == csvft_pkg::QUOTE_BYTE));
        send_word(c, 1'b0);
      end
    end
    if (is_quoted) send_word(csvft_pkg::QUOTE_BYTE, 1'b0);
    term = $urandom_range(0, 99);
    if (term < 70)
      send_word(delim, 1'b0);
    else if (term < 95)
      send_word(csvft_pkg::NEWLINE_BYTE, 1'b0);
    else
      send_word(8'($urandom_range(0, 255)), 1'b1);
  endtask

  // Drop valid, wait for every expected word, then let the pipeline settle
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (token_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_delimiter(input logic [7:0] d);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= d;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    delim = d;
  endtask

  // Receiver: random stalls when snk_idle is set, plus a long hold-off on request
  initial begin : result_sink
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold_req) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        long_hold_req = 1'b0;
      end
      stall = snk_idle ? $urandom_range(0, 4) : 0;
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // Compare each accepted result word with the oldest expected one
  always @(posedge clk) begin : result_check
    csvft_pkg::result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (token_q.size() == 0) begin
        report_mismatch("unexpected word, kind", out_ch.kind, PREDICT);
      end else begin
        want = token_q.pop_front();
        if (out_ch.kind !== want.kind)
          report_mismatch("kind", out_ch.kind, want.kind);
        if (out_ch.out_byte !== want.out_byte)
          report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
        if (out_ch.last !== want.last)
          report_mismatch("last", out_ch.last, want.last);
      end
    end
  end

  // Watchdog: end the run when no word moves on either side for too long
  initial begin : watchdog
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("** csv_field_tokenizer: FAILED **");
    $finish;
  end

  initial begin : stimulus
    stim_row_t row;
    csvft_pkg::result_t r0, r1;
    int n, p, phase_start;
    rst <= 1'b1;
    cfg_wr_en <= 1'b0;
    cfg_wr_data <= 8'h00;
    in_ch.valid <= 1'b0;
    in_ch.in_byte <= 8'h00;
    in_ch.end_of_input <= 1'b0;
    blank_set = '{SPACE_BYTE, TAB_BYTE, VT_BYTE, FF_BYTE, CR_BYTE};
    phase_delims = '{8'h3B, 8'h00, 8'hFF, csvft_pkg::QUOTE_BYTE, SPACE_BYTE,
                     csvft_pkg::NEWLINE_BYTE, TAB_BYTE, csvft_pkg::DELIM_RESET, 8'h00};

    // end of input right after reset, byte ignored
    add_row(8'hFF, 1'b1, 1, csvft_pkg::KIND_NONE);
    // empty fields: delimiter and newline with nothing taken
    add_row(csvft_pkg::DELIM_RESET, 1'b0, 1, csvft_pkg::KIND_NONE);
    add_row(csvft_pkg::NEWLINE_BYTE, 1'b0, 1, csvft_pkg::KIND_NONE);
    // leading white space is skipped
    add_row(SPACE_BYTE, 1'b0, 0);
    add_row(TAB_BYTE, 1'b0, 0);
    add_row(VT_BYTE, 1'b0, 0);
    add_row(FF_BYTE, 1'b0, 0);
    add_row(CR_BYTE, 1'b0, 0);
    // byte extremes, then newline after a started field gives two words
    add_row(8'h00, 1'b0, 1, csvft_pkg::KIND_BYTE, 8'h00);
    add_row(8'hFF, 1'b0, 1, csvft_pkg::KIND_BYTE, 8'hFF);
    add_row(csvft_pkg::NEWLINE_BYTE, 1'b0, 2, csvft_pkg::KIND_END, 8'h00,
            csvft_pkg::KIND_NONE);
    // opening quote, a second quote at field start, newline inside quotes
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, 0);
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, 0);
    add_row(csvft_pkg::NEWLINE_BYTE, 1'b0, 1, csvft_pkg::KIND_NONE);
    // quoted field: blank and delimiter kept, doubled quote, quote then newline
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, 0);
    add_row(SPACE_BYTE, 1'b0, PREDICT);
    add_row(csvft_pkg::DELIM_RESET, 1'b0, PREDICT);
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, PREDICT);
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, PREDICT);
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, PREDICT);
    add_row(csvft_pkg::NEWLINE_BYTE, 1'b0, PREDICT);
    // closing quote then delimiter
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, 0);
    add_row(8'h78, 1'b0, PREDICT);
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, PREDICT);
    add_row(csvft_pkg::DELIM_RESET, 1'b0, PREDICT);
    // end of input with a quote held
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, 0);
    add_row(8'h79, 1'b0, PREDICT);
    add_row(csvft_pkg::QUOTE_BYTE, 1'b0, PREDICT);
    add_row(8'h00, 1'b1, PREDICT);

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // directed part
    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      offer_word(row.b, row.eoi);
      n = tokenize(row.b, row.eoi, r0, r1);
      if (row.n != PREDICT) begin
        n = row.n;
        r0 = row.r0;
        r1 = row.r1;
      end
      if (n > 0) token_q.push_back(r0);
      if (n > 1) token_q.push_back(r1);
    end
    drain_results();

    // random part: one delimiter per phase, idling varied between phases
    for (p = 0; p < NUM_PHASES; p++) begin
      set_delimiter(p == NUM_PHASES - 1 ? 8'($urandom_range(0, 255)) : phase_delims[p]);
      src_idle = (p % 4) != 0;
      snk_idle = (p % 3) != 1;
      if (p == 1 || p == 6) long_hold_req = 1'b1;
      phase_start = items_sent;
      while (items_sent < phase_start + PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85)
          send_field();
        else
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
      end
      drain_results();
    end

    repeat (2 * SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("** csv_field_tokenizer: PASSED **");
    else
      $display("** csv_field_tokenizer: FAILED **");
    $finish;
  end

endmodule
